### sv/sbb_pkg.sv
// Shared types, codes and defaults for the separable box blur block.
package sbb_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_RADIUS = 32;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLUR_RADIUS  = 2'd2;

   localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
   localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;
   localparam logic [5:0]  RST_BLUR_RADIUS  = 6'd20;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       last_of_frame;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WR_PIX,
      ST_H_START,
      ST_H_SUM,
      ST_H_DIV,
      ST_H_WR,
      ST_ADV_IN,
      ST_CHECK,
      ST_V_START,
      ST_V_SUM,
      ST_V_DIV,
      ST_V_OUT
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic write_pixel;
      logic h_init;
      logic x_next;
      logic h_start;
      logic v_start;
      logic div_start;
      logic line_write;
      logic adv_in;
      logic out_load;
      logic adv_out;
   } cmd_type;

   typedef struct packed {
      logic take_pixel;
      logic do_horiz;
      logic last_pass;
      logic sum_done;
      logic div_done;
      logic out_avail;
      logic rsp_free;
   } status_type;

endpackage

### sv/sbb_ram.sv
// Generic simple dual-port RAM with registered read.
module sbb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/sbb_ctrl.sv
// Sequencer for the separable box blur: item intake, passes and result hand-off.
module sbb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sbb_pkg::status_type status,
   output sbb_pkg::cmd_type    cmd
);

   import sbb_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.take_pixel) begin
                  cmd.latch_req = 1'b1;
                  state_in      = ST_WR_PIX;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_WR_PIX: begin
            cmd.write_pixel = 1'b1;
            if (status.do_horiz) begin
               cmd.h_init = 1'b1;
               state_in   = ST_H_START;
            end else begin
               state_in = ST_ADV_IN;
            end
         end
         ST_H_START: begin
            cmd.h_start = 1'b1;
            state_in    = ST_H_SUM;
         end
         ST_H_SUM: begin
            if (status.sum_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_H_DIV;
            end
         end
         ST_H_DIV: begin
            if (status.div_done) begin
               state_in = ST_H_WR;
            end
         end
         ST_H_WR: begin
            cmd.line_write = 1'b1;
            if (status.last_pass) begin
               state_in = ST_ADV_IN;
            end else begin
               cmd.x_next = 1'b1;
               state_in   = ST_H_START;
            end
         end
         ST_ADV_IN: begin
            cmd.adv_in = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.out_avail ? ST_V_START : ST_IDLE;
         end
         ST_V_START: begin
            cmd.v_start = 1'b1;
            state_in    = ST_V_SUM;
         end
         ST_V_SUM: begin
            if (status.sum_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_V_DIV;
            end
         end
         ST_V_DIV: begin
            if (status.div_done) begin
               state_in = ST_V_OUT;
            end
         end
         ST_V_OUT: begin
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               cmd.adv_out  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/sbb_datapath.sv
// Datapath: positions, window walk, shared divider, stores and result register.
module sbb_datapath #(
   parameter int MAX_WIDTH  = sbb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sbb_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = sbb_pkg::DEF_MAX_RADIUS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sbb_pkg::req_type                   req_data,
   input  logic                               csr_write,
   input  logic [sbb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sbb_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               rsp_ready,
   input  sbb_pkg::cmd_type                   cmd,
   output sbb_pkg::status_type                status,
   output logic                               rsp_valid,
   output sbb_pkg::rsp_type                   rsp_data
);

   import sbb_pkg::*;

   localparam int WIN    = 2 * MAX_RADIUS + 1;
   localparam int SW     = $clog2(WIN);
   localparam int SW1    = SW + 1;
   localparam int NW     = $clog2(WIN + 1);
   localparam int SUMW   = 8 + SW;
   localparam int SUMW1  = SUMW + 1;
   localparam int CW     = $clog2(MAX_WIDTH + 1);
   localparam int CH     = $clog2(MAX_HEIGHT + 1);
   localparam int RW     = $clog2(MAX_RADIUS + 1);
   localparam int PW     = $clog2(MAX_WIDTH + MAX_HEIGHT + 2 * MAX_RADIUS + 2);
   localparam int LDEPTH = WIN * MAX_WIDTH;
   localparam int LA     = $clog2(LDEPTH);

   // configuration
   logic [10:0] width_raw_ff, height_raw_ff;
   logic [5:0]  radius_raw_ff;
   logic        wr_width, wr_height, wr_radius, cfg_hit;

   // positions
   logic [CW-1:0] in_x_ff, out_x_ff, x_cur_ff;
   logic [CH-1:0] in_y_ff, out_y_ff;
   logic [SW-1:0] in_xs_ff, in_ys_ff, out_ys_ff;

   // window walk
   logic [SW-1:0]           slot_ptr_ff;
   logic [NW-1:0]           left_ff, cnt_ff;
   logic                    mode_ff, rd_pend_ff;
   logic [2:0][SUMW-1:0]    acc_ff;

   // divider
   logic [2:0][SUMW-1:0]    rem_ff;
   logic [2:0][7:0]         quo_ff;
   logic [2:0]              step_ff;
   logic                    div_busy_ff;
   logic [SUMW1-1:0]        trial;

   logic [23:0]             pix_ff;
   rsp_type                 rsp_data_ff;
   logic                    rsp_valid_ff;

   logic [CW-1:0] w;
   logic [CH-1:0] h;
   logic [RW-1:0] r;
   logic [PW-1:0] wp, hp, rp, ixp, iyp, oxp, oyp, xcp;
   logic [PW-1:0] x_start, x_end, hlo, hy, hx, vlo, dy;
   logic [NW-1:0] hcnt, vcnt;
   logic [SW1-1:0] hy_sum;
   logic [SW-1:0]  hy_slot;
   logic           end_row, ge_r, in_done, last_out;
   logic [LA-1:0]  line_wr_addr, line_rd_addr;
   logic [23:0]    row_rd, line_rd, walk_data;

   always_comb begin
      wr_width  = 1'b0;
      wr_height = 1'b0;
      wr_radius = 1'b0;
      unique case (csr_index)
         REG_IMAGE_WIDTH:  wr_width  = csr_write;
         REG_IMAGE_HEIGHT: wr_height = csr_write;
         REG_BLUR_RADIUS:  wr_radius = csr_write;
         default: ;
      endcase
   end
   assign cfg_hit = wr_width | wr_height | wr_radius;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff  <= RST_IMAGE_WIDTH;
         height_raw_ff <= RST_IMAGE_HEIGHT;
         radius_raw_ff <= RST_BLUR_RADIUS;
      end else begin
         if (wr_width)  width_raw_ff  <= csr_data;
         if (wr_height) height_raw_ff <= csr_data;
         if (wr_radius) radius_raw_ff <= csr_data[5:0];
      end
   end

   // saturate the raw settings; zero width or height acts as one
   assign w = (width_raw_ff == '0) ? CW'(1) :
              (width_raw_ff > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_raw_ff);
   assign h = (height_raw_ff == '0) ? CH'(1) :
              (height_raw_ff > MAX_HEIGHT) ? CH'(MAX_HEIGHT) : CH'(height_raw_ff);
   assign r = (radius_raw_ff > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_raw_ff);

   assign wp  = PW'(w);
   assign hp  = PW'(h);
   assign rp  = PW'(r);
   assign ixp = PW'(in_x_ff);
   assign iyp = PW'(in_y_ff);
   assign oxp = PW'(out_x_ff);
   assign oyp = PW'(out_y_ff);
   assign xcp = PW'(x_cur_ff);

   // horizontal pass planning; every pass of an item ends at the newest pixel
   assign in_done = (in_y_ff == h);
   assign end_row = (ixp == wp - PW'(1));
   assign ge_r    = (ixp >= rp);
   assign x_start = ge_r ? ixp - rp : '0;
   assign x_end   = end_row ? ixp : x_start;
   assign hlo     = (xcp >= rp) ? xcp - rp : '0;
   assign hcnt    = NW'(ixp - hlo + PW'(1));

   // vertical pass planning
   assign hy   = (oyp + rp <= hp - PW'(1)) ? oyp + rp : hp - PW'(1);
   assign hx   = (oxp + rp <= wp - PW'(1)) ? oxp + rp : wp - PW'(1);
   assign vlo  = (oyp >= rp) ? oyp - rp : '0;
   assign vcnt = NW'(hy - vlo + PW'(1));
   assign dy   = hy - oyp;
   assign hy_sum  = SW1'(out_ys_ff) + SW1'(dy);
   assign hy_slot = (hy_sum >= SW1'(WIN)) ? SW'(hy_sum - SW1'(WIN)) : SW'(hy_sum);
   assign last_out = (oxp == wp - PW'(1)) && (oyp == hp - PW'(1));

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         in_x_ff   <= '0;
         in_y_ff   <= '0;
         in_xs_ff  <= '0;
         in_ys_ff  <= '0;
         out_x_ff  <= '0;
         out_y_ff  <= '0;
         out_ys_ff <= '0;
      end else begin
         if (cmd.adv_in) begin
            if (end_row) begin
               in_x_ff  <= '0;
               in_xs_ff <= '0;
               in_y_ff  <= in_y_ff + CH'(1);
               in_ys_ff <= (in_ys_ff == SW'(WIN - 1)) ? '0 : in_ys_ff + SW'(1);
            end else begin
               in_x_ff  <= in_x_ff + CW'(1);
               in_xs_ff <= (in_xs_ff == SW'(WIN - 1)) ? '0 : in_xs_ff + SW'(1);
            end
         end
         if (cmd.adv_out) begin
            if (last_out) begin
               // frame complete: both sides start over
               in_x_ff   <= '0;
               in_y_ff   <= '0;
               in_xs_ff  <= '0;
               in_ys_ff  <= '0;
               out_x_ff  <= '0;
               out_y_ff  <= '0;
               out_ys_ff <= '0;
            end else if (oxp == wp - PW'(1)) begin
               out_x_ff  <= '0;
               out_y_ff  <= out_y_ff + CH'(1);
               out_ys_ff <= (out_ys_ff == SW'(WIN - 1)) ? '0 : out_ys_ff + SW'(1);
            end else begin
               out_x_ff <= out_x_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.h_init) begin
         x_cur_ff <= CW'(x_start);
      end else if (cmd.x_next) begin
         x_cur_ff <= x_cur_ff + CW'(1);
      end
      if (cmd.latch_req) begin
         pix_ff <= {req_data.in_red, req_data.in_green, req_data.in_blue};
      end
   end

   // window walk: one entry read a cycle, newest first, each summed in the cycle after its read
   assign walk_data = mode_ff ? line_rd : row_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else if (cmd.h_start || cmd.v_start) begin
         left_ff    <= cmd.v_start ? vcnt : hcnt;
         rd_pend_ff <= 1'b0;
      end else begin
         if (left_ff != '0) begin
            left_ff <= left_ff - NW'(1);
         end
         rd_pend_ff <= (left_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.h_start || cmd.v_start) begin
         slot_ptr_ff <= cmd.v_start ? hy_slot : in_xs_ff;
         cnt_ff      <= cmd.v_start ? vcnt : hcnt;
         mode_ff     <= cmd.v_start;
         acc_ff      <= '0;
      end else begin
         if (left_ff != '0) begin
            slot_ptr_ff <= (slot_ptr_ff == '0) ? SW'(WIN - 1) : slot_ptr_ff - SW'(1);
         end
         if (rd_pend_ff) begin
            for (int c = 0; c < 3; c++) begin
               acc_ff[c] <= acc_ff[c] + SUMW'(walk_data[8*c +: 8]);
            end
         end
      end
   end

   // restoring divider, one quotient bit a step; quotient always fits 8 bits
   assign trial = SUMW1'(cnt_ff) << step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && step_ff == '0) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff  <= acc_ff;
         quo_ff  <= '0;
         step_ff <= 3'd7;
      end else if (div_busy_ff) begin
         for (int c = 0; c < 3; c++) begin
            if (SUMW1'(rem_ff[c]) >= trial) begin
               rem_ff[c]          <= rem_ff[c] - trial[SUMW-1:0];
               quo_ff[c][step_ff] <= 1'b1;
            end
         end
         step_ff <= step_ff - 3'd1;
      end
   end

   assign line_wr_addr = LA'(LA'(in_ys_ff) * LA'(MAX_WIDTH)) + LA'(x_cur_ff);
   assign line_rd_addr = LA'(LA'(slot_ptr_ff) * LA'(MAX_WIDTH)) + LA'(out_x_ff);

   sbb_ram #(
      .WIDTH (24),
      .DEPTH (WIN)
   ) u_row_window (
      .clock   (clock),
      .wr_en   (cmd.write_pixel),
      .wr_addr (in_xs_ff),
      .wr_data (pix_ff),
      .rd_addr (slot_ptr_ff),
      .rd_data (row_rd)
   );

   sbb_ram #(
      .WIDTH (24),
      .DEPTH (LDEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (cmd.line_write),
      .wr_addr (line_wr_addr),
      .wr_data ({quo_ff[2], quo_ff[1], quo_ff[0]}),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.out_red       <= quo_ff[2];
         rsp_data_ff.out_green     <= quo_ff[1];
         rsp_data_ff.out_blue      <= quo_ff[0];
         rsp_data_ff.last_of_frame <= last_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.take_pixel = (req_data.command == CMD_PIXEL) && !in_done;
   assign status.do_horiz   = end_row || ge_r;
   assign status.last_pass  = (xcp == x_end);
   assign status.sum_done   = (left_ff == '0) && !rd_pend_ff;
   assign status.div_done   = !div_busy_ff;
   assign status.out_avail  = (iyp > hy) || ((iyp == hy) && (ixp > hx));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

### sv/separable_box_blur_rgb_top.sv
// Top level of the separable box blur over an RGB raster stream.
//
// Pixels go in on req_ in raster order; blurred pixels come out on rsp_ in raster
// order, lagging by blur_radius rows plus blur_radius pixels, and flush beats drain
// the tail. Writing any register restarts the frame. An item is handled one at a
// time: it is accepted and its pixel written, then horizontal results are made,
// each a walk over its window (at most 2*radius+1 entries) and a division, none
// for the first radius pixels of a row, one for each later pixel and up to radius+1
// at a row end; the input then advances, the output check runs, and an item yields
// at most one output, from a vertical walk and a division. The pace is set by the
// single read port of the row window and line store, walked one entry a cycle, and
// the shared 8-step divider. The stores need no clearing after reset.
module separable_box_blur_rgb_top #(
   parameter int MAX_WIDTH  = sbb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sbb_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = sbb_pkg::DEF_MAX_RADIUS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  sbb_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sbb_pkg::rsp_type               rsp_data,
   input  logic                           csr_write,
   input  logic [sbb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbb_pkg::CSR_DATA_W-1:0] csr_data
);

   import sbb_pkg::*;

   cmd_type    cmd;
   status_type status;

   sbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sbb_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a result never overwrites one still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.rsp_free)
      else $error("result loaded over a pending beat");

   // the divider starts only on a finished window sum
   a_div_after_sum: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> status.sum_done)
      else $error("divide started before window sum completed");

   // no new beat is taken while a division is in flight
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      !status.div_done |-> !req_ready)
      else $error("input accepted during division");

endmodule
